/* rtl/core/aid_pkg.sv */
// aid_pkg: shared types and codes for the instruction decoder
// no dependencies
package aid_pkg;

	localparam logic [4:0] F_DP = 5'd0, F_MUL = 5'd1, F_LMUL = 5'd2, F_SWP = 5'd3,
		F_HW = 5'd4, F_BX = 5'd5, F_NOP = 5'd6, F_MRS = 5'd7, F_MSR = 5'd8,
		F_BR = 5'd9, F_LDR = 5'd10, F_LDM = 5'd11, F_SWI = 5'd12, F_CDP = 5'd13,
		F_MRC = 5'd14, F_LDC = 5'd15, F_FOP = 5'd16, F_FRX = 5'd17, F_FLD = 5'd18,
		F_UND = 5'd19;

	localparam int M_S = 0, M_BL = 1, M_PRE = 2, M_UP = 3, M_WB = 4, M_LD = 5,
		M_USR = 6, M_PCR = 7, M_ODD = 8;

	localparam logic [3:0] SK_LSL = 4'd1, SK_RRX = 4'd5, SK_REG = 4'd6;
	localparam logic [3:0] REG_PC = 4'd15;
	localparam logic [23:0] BX_PATTERN = 24'h12fff1;
	localparam logic [31:0] NOP_WORD = 32'he1a00000;
	localparam logic [31:0] PC_AHEAD = 32'd8;

	typedef struct packed {
		logic [4:0]  form;
		logic [3:0]  operation;
		logic [3:0]  condition;
		logic [3:0]  dest_reg;
		logic [3:0]  base_reg;
		logic [3:0]  operand_reg;
		logic [3:0]  shift_reg;
		logic [3:0]  shift_kind;
		logic [5:0]  shift_amount;
		logic [8:0]  modifiers;
		logic [31:0] immediate;
	} dec_rec_t;

	// what stage 2 needs to build a target
	typedef struct packed {
		logic        add_en;
		logic        up;
		logic [31:0] offset;
	} tgt_ctl_t;

endpackage

/* rtl/core/arm_instruction_decoder_top.sv */
// arm_instruction_decoder_top: pipelined armv4 / fpa instruction decoder
// depends on aid_pkg, aid_decode, aid_target
//
// usage
// - input channel: instruction_word and instruction_address, one transfer per
//   cycle when valid_in is high and stall_in is low
// - output channel: one decoded record per input transfer, in order, taken
//   when valid_out is high and stall_out is low
// - three register stages: s1 captures the raw word, s2 holds the field
//   decode and target controls, s3 holds the finished record and target
// - valid_out rises once the item has passed s1 and s2 and is loaded into
//   s3; the output transfer then takes place whenever stall_out is low
// - throughput is one instruction per cycle; a new item enters every cycle
//   while the output side keeps taking results
// - the decoder's field logic sits between s1 and s2, the target adder
//   between s2 and s3, so each stage holds about one adder or decode cloud
// - a stall at the output freezes only stages that are full; bubbles ahead
//   of it still close up, so stall_in rises only when all stages are full
// - reset (arst_n low) clears all valid bits; the payload is left as is
// - there are no configuration registers and no state between items
module arm_instruction_decoder_top import aid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [31:0] instruction_word,
	input  logic [31:0] instruction_address,
	output logic        valid_out,
	input  logic        stall_out,
	output logic [4:0]  form,
	output logic [3:0]  operation,
	output logic [3:0]  condition,
	output logic [3:0]  dest_reg,
	output logic [3:0]  base_reg,
	output logic [3:0]  operand_reg,
	output logic [3:0]  shift_reg,
	output logic [3:0]  shift_kind,
	output logic [5:0]  shift_amount,
	output logic [8:0]  modifiers,
	output logic [31:0] immediate,
	output logic [31:0] target_address
);

	// stage valids
	logic v_s1, v_s2, v_s3;
	// per-stage advance enables
	logic en_s1, en_s2, en_s3;

	logic [31:0] word_s1, addr_s1, addr_s2, tgt_s3;
	dec_rec_t    rec_d, rec_s2, rec_s3;
	tgt_ctl_t    tgt_d, tgt_s2;
	logic [31:0] tgt_d3;

	// a stage loads when it is empty or the one after it moves on
	assign en_s3 = !v_s3 || !stall_out;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign stall_in = !en_s1;

	aid_decode u_dec (
		.word (word_s1),
		.rec  (rec_d),
		.tgt  (tgt_d)
	);

	aid_target u_tgt (
		.tgt     (tgt_s2),
		.address (addr_s2),
		.target  (tgt_d3)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= valid_in;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// payload, loaded only with a live item so a stalled record holds
	always_ff @(posedge clk) begin
		if (en_s1 && valid_in) begin
			word_s1 <= instruction_word;
			addr_s1 <= instruction_address;
		end
		if (en_s2 && v_s1) begin
			rec_s2 <= rec_d;
			tgt_s2 <= tgt_d;
			addr_s2 <= addr_s1;
		end
		if (en_s3 && v_s2) begin
			rec_s3 <= rec_s2;
			tgt_s3 <= tgt_d3;
		end
	end

	assign valid_out      = v_s3;
	assign form           = rec_s3.form;
	assign operation      = rec_s3.operation;
	assign condition      = rec_s3.condition;
	assign dest_reg       = rec_s3.dest_reg;
	assign base_reg       = rec_s3.base_reg;
	assign operand_reg    = rec_s3.operand_reg;
	assign shift_reg      = rec_s3.shift_reg;
	assign shift_kind     = rec_s3.shift_kind;
	assign shift_amount   = rec_s3.shift_amount;
	assign modifiers      = rec_s3.modifiers;
	assign immediate      = rec_s3.immediate;
	assign target_address = tgt_s3;

	// stall_in only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		stall_in |-> (v_s1 && v_s2 && v_s3 && stall_out))
		else $error("input stalled with a free stage");

	// a held output record keeps its target
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && stall_out) |=> (valid_out && $stable(tgt_s3) && $stable(rec_s3)))
		else $error("held output changed");

	// the target is zero unless the record is pc-relative
	a_tgt_pcr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && !modifiers[M_PCR]) |-> (target_address == '0))
		else $error("target without pc-relative flag");

	// a transfer into s1 shows up in s2 the next cycle when s2 is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2) |=> v_s2)
		else $error("stage 1 item lost");

endmodule

/* rtl/core/aid_decode.sv */
// aid_decode: field decode of one instruction word, combinational
// depends on aid_pkg
module aid_decode import aid_pkg::*; (
	input  logic [31:0] word,
	output dec_rec_t    rec,
	output tgt_ctl_t    tgt
);

	function automatic void shop(input logic [31:0] w, inout dec_rec_t r);
		logic [6:0] t;
		t = w[11:5];
		r.operand_reg = w[3:0];
		if (w[4]) begin
			r.shift_kind = SK_REG + {2'b00, w[6:5]};
			r.shift_reg = w[11:8];
		end else if (t == 7'd3) begin
			r.shift_kind = SK_RRX;
		end else if (t == 7'd1 || t == 7'd2) begin
			r.shift_kind = SK_LSL + {1'b0, t[2:0]};
			r.shift_amount = 6'd32;
		end else begin
			r.shift_kind = SK_LSL + {2'b00, w[6:5]};
			r.shift_amount = {1'b0, w[11:7]};
		end
	endfunction

	function automatic void xfl(input logic [31:0] w, inout dec_rec_t r);
		r.modifiers[M_PRE] = w[24];
		r.modifiers[M_UP] = w[23];
		r.modifiers[M_WB] = w[21];
		r.modifiers[M_LD] = w[20];
	endfunction

	function automatic void fpk(input logic [31:0] w, input logic mon, inout dec_rec_t r);
		r.immediate = {26'd0, w[3], mon & w[15], w[6:5], w[19], w[7]};
		r.base_reg = {1'b0, w[18:16]};
		r.operand_reg = {1'b0, w[2:0]};
	endfunction

	function automatic logic [3:0] w_op(input logic [31:0] w);
		return w[24:21];
	endfunction

	always_comb begin
		dec_rec_t r;
		tgt_ctl_t g;
		logic [3:0] op;
		logic [3:0] top;
		logic [3:0] cp;
		logic [1:0] n;
		logic [63:0] rr;
		logic done;
		r = '0;
		g = '0;
		done = 1'b0;
		op = w_op(word);
		top = word[27:24];
		cp = word[11:8];
		n = '0;
		rr = '0;
		r.condition = word[31:28];
		g.up = word[23];
		if (top <= 4'd3) begin
			r.dest_reg = word[15:12];
			r.base_reg = word[19:16];
			if (top == 4'd0 && word[23] && word[7:4] == 4'd9) begin
				r.form = F_LMUL;
				r.operation = {2'b00, word[22], word[21]};
				r.operand_reg = word[3:0];
				r.shift_reg = word[11:8];
				r.modifiers[M_S] = word[20];
				done = 1'b1;
			end else if (word[4] && word[7]) begin
				if (!word[5] && !word[6]) begin
					if (word[27:22] == 6'd0) begin
						r.form = F_MUL;
						r.operation = {3'b000, word[21]};
						r.dest_reg = word[19:16];
						r.base_reg = word[15:12];
						r.operand_reg = word[3:0];
						r.shift_reg = word[11:8];
						r.modifiers[M_S] = word[20];
						done = 1'b1;
					end else if (word[27:23] == 5'd2 && word[11:8] == 4'd0) begin
						r.form = F_SWP;
						r.operand_reg = word[3:0];
						r.modifiers[M_BL] = word[22];
						done = 1'b1;
					end
				end else if (!word[25] && (word[20] || !word[6])) begin
					r.form = F_HW;
					r.operation = {2'b00, word[6:5]};
					xfl(word, r);
					if (word[22]) begin
						r.immediate = {24'd0, word[11:8], word[3:0]};
					end else begin
						r.operand_reg = word[3:0];
						r.shift_kind = SK_LSL;
					end
					done = 1'b1;
				end
			end
			if (!done) begin
				if (word[27:4] == BX_PATTERN) begin
					r.form = F_BX;
					r.dest_reg = '0;
					r.base_reg = '0;
					r.operand_reg = word[3:0];
				end else if (word == NOP_WORD) begin
					r.form = F_NOP;
					r.dest_reg = '0;
					r.base_reg = '0;
				end else begin
					if (op[3:2] == 2'b10 && !word[20]) begin
						r.operation = {3'b000, word[22]};
						if (!op[0]) begin
							r.form = F_MRS;
							r.modifiers[M_ODD] = (word[11:0] != 12'd0) ||
								(r.base_reg != REG_PC);
							done = 1'b1;
						end else begin
							r.form = F_MSR;
							r.modifiers[M_ODD] = r.dest_reg != REG_PC;
						end
					end else begin
						r.form = F_DP;
						r.operation = op;
						r.modifiers[M_S] = word[20] && (op[3:2] != 2'b10 || r.dest_reg == REG_PC);
					end
					if (!done) begin
						if (word[25]) begin
							// rotate right by twice the rotate field
							rr = {24'd0, word[7:0], 24'd0, word[7:0]} >> {word[11:8], 1'b0};
							r.immediate = rr[31:0];
							if (word[11:8] == 4'd0) r.immediate = {24'd0, word[7:0]};
						end else begin
							shop(word, r);
						end
					end
				end
			end
		end else if (top == 4'hA || top == 4'hB) begin
			r.form = F_BR;
			r.operation = {3'b000, word[24]};
			r.immediate = {{6{word[23]}}, word[23:0], 2'b00};
			r.modifiers[M_PCR] = 1'b1;
			g.add_en = 1'b1;
			g.up = 1'b1;
			g.offset = r.immediate;
		end else if ((top == 4'd6 || top == 4'd7) && word[4]) begin
			r.form = F_UND;
		end else if (top >= 4'd4 && top <= 4'd7) begin
			r.form = F_LDR;
			r.dest_reg = word[15:12];
			r.base_reg = word[19:16];
			xfl(word, r);
			r.modifiers[M_BL] = word[22];
			r.modifiers[M_USR] = !word[24] && word[21];
			if (!word[25]) begin
				r.immediate = {20'd0, word[11:0]};
				if (r.base_reg == REG_PC && word[24]) begin
					r.modifiers[M_PCR] = 1'b1;
					g.add_en = 1'b1;
					g.offset = r.immediate;
				end
			end else begin
				shop(word, r);
			end
		end else if (top == 4'd8 || top == 4'd9) begin
			r.form = F_LDM;
			r.operation = {2'b00, word[24:23]};
			r.base_reg = word[19:16];
			xfl(word, r);
			r.modifiers[M_USR] = word[22];
			r.immediate = {16'd0, word[15:0]};
		end else if (top == 4'hF) begin
			r.form = F_SWI;
			r.immediate = {8'd0, word[23:0]};
		end else if (top == 4'hE) begin
			if (cp == 4'd1) begin
				if (!word[4]) begin
					r.form = F_FOP;
					r.operation = word[23:20];
					r.dest_reg = {1'b0, word[14:12]};
					fpk(word, 1'b1, r);
					r.modifiers[M_ODD] = word[15] && word[18:16] != 3'd0;
				end else begin
					r.form = F_FRX;
					r.dest_reg = word[15:12];
					fpk(word, 1'b0, r);
					if (r.dest_reg == REG_PC)
						r.operation = (word[20] && word[23]) ? 4'd6 + {2'b00, word[22:21]} : 4'd15;
					else
						r.operation = (word[23:20] < 4'd6) ? word[23:20] : 4'd15;
				end
			end else begin
				r.dest_reg = word[15:12];
				r.base_reg = word[19:16];
				r.operand_reg = word[3:0];
				r.immediate = {25'd0, word[7:5], cp};
				if (!word[4]) begin
					r.form = F_CDP;
					r.operation = word[23:20];
				end else begin
					r.form = F_MRC;
					r.operation = {1'b0, word[23:21]};
					r.modifiers[M_LD] = word[20];
				end
			end
		end else begin
			r.base_reg = word[19:16];
			r.immediate = {22'd0, word[7:0], 2'b00};
			xfl(word, r);
			r.modifiers[M_BL] = word[22];
			if ((cp == 4'd1 || cp == 4'd2) && (word[24] || word[21])) begin
				r.form = F_FLD;
				r.dest_reg = {1'b0, word[14:12]};
				n = {word[22], word[15]};
				if (cp == 4'd1) r.operation = {2'b00, n};
				else r.operation = 4'd3 + ((n == 2'd0) ? 4'd4 : {2'b00, n});
			end else begin
				r.form = F_LDC;
				r.operation = cp;
				r.dest_reg = word[15:12];
			end
			if (r.base_reg == REG_PC && word[24]) begin
				r.modifiers[M_PCR] = 1'b1;
				g.add_en = 1'b1;
				g.offset = r.immediate;
			end
		end
		rec = r;
		tgt = g;
	end

endmodule

/* rtl/core/aid_target.sv */
// aid_target: pc-relative target adder, combinational
// depends on aid_pkg
module aid_target import aid_pkg::*; (
	input  tgt_ctl_t    tgt,
	input  logic [31:0] address,
	output logic [31:0] target
);

	always_comb begin
		if (!tgt.add_en) target = '0;
		else if (tgt.up) target = address + tgt.offset + PC_AHEAD;
		else target = address - tgt.offset + PC_AHEAD;
	end

endmodule
